// ----- hw/rtl/icmpprc_pkg.sv -----
// shared types and constants for the icmp probe reply classifier
package icmpprc_pkg;

  localparam int unsigned CountW   = 11;
  localparam int unsigned HdrLenW  = 6;
  localparam int unsigned BaseW    = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CountW-1:0]  CountMax     = 11'd2047;
  localparam logic [HdrLenW-1:0] HdrLenMin    = 6'd20;
  localparam logic [BaseW-1:0]   V6InnerBase  = 7'd48;
  localparam logic [BaseW-1:0]   V4InnerOfs   = 7'd28;

  localparam logic [7:0] V4EchoReply   = 8'd0;
  localparam logic [7:0] V4TimeExceed  = 8'd11;
  localparam logic [7:0] V6EchoReply   = 8'd129;
  localparam logic [7:0] V6TimeExceed  = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFamily = 2'd0,
    CfgIdent  = 2'd1,
    CfgSeq    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        family;
    logic [15:0] ident;
    logic [15:0] seq;
  } cfg_t;

  typedef struct packed {
    logic matched;
    logic reached;
  } result_t;

endpackage

// ----- hw/rtl/icmpprc_parser.sv -----
// per-packet parse state and end-of-packet classification
module icmpprc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  icmpprc_pkg::cfg_t    cfg_i,
  output icmpprc_pkg::result_t result_o
);

  logic [icmpprc_pkg::CountW-1:0]  count_q, count_d;
  logic [icmpprc_pkg::HdrLenW-1:0] hl_q, hl_d, hl_raw, hl_new;
  logic [7:0]                      type_q, type_d, code_q, code_d;
  logic                            omatch_q, omatch_d, imatch_q, imatch_d;
  logic [icmpprc_pkg::BaseW-1:0]   obase, ibase;
  logic [icmpprc_pkg::CountW-1:0]  obase_w, ibase_w, hl_w;
  logic                            v4_len_ok, v4_te_len_ok, v6_len_ok, v6_te_len_ok;

  function automatic logic track(
    input logic        flag,
    input logic [10:0] pos,
    input logic [10:0] base,
    input logic [7:0]  b,
    input logic [15:0] ident,
    input logic [15:0] seq
  );
    logic [10:0] rel;
    logic [7:0]  want;
    logic        res;
    rel  = pos - base;
    want = ident[15:8];
    res  = flag;
    if (pos >= base + 11'd4 && pos <= base + 11'd7) begin
      unique case (rel[1:0])
        2'd0: want = ident[15:8];
        2'd1: want = ident[7:0];
        2'd2: want = seq[15:8];
        2'd3: want = seq[7:0];
        default: want = ident[15:8];
      endcase
      if (rel[1:0] == 2'd0) begin
        res = (b == want);
      end else begin
        res = flag && (b == want);
      end
    end
    return res;
  endfunction

  always_comb begin
    hl_raw = {data_byte_i[3:0], 2'b00};
    hl_new = (hl_raw < icmpprc_pkg::HdrLenMin) ? icmpprc_pkg::HdrLenMin : hl_raw;
    hl_d   = (count_q == '0) ? hl_new : hl_q;
    hl_w   = {{(icmpprc_pkg::CountW-icmpprc_pkg::HdrLenW){1'b0}}, hl_d};

    if (cfg_i.family) begin
      obase = '0;
      ibase = icmpprc_pkg::V6InnerBase;
    end else begin
      obase = {1'b0, hl_d};
      ibase = {1'b0, hl_d} + icmpprc_pkg::V4InnerOfs;
    end
    obase_w = {{(icmpprc_pkg::CountW-icmpprc_pkg::BaseW){1'b0}}, obase};
    ibase_w = {{(icmpprc_pkg::CountW-icmpprc_pkg::BaseW){1'b0}}, ibase};

    type_d   = (count_q == obase_w) ? data_byte_i : type_q;
    code_d   = (count_q == obase_w + 11'd1) ? data_byte_i : code_q;
    omatch_d = track(omatch_q, count_q, obase_w, data_byte_i, cfg_i.ident, cfg_i.seq);
    imatch_d = track(imatch_q, count_q, ibase_w, data_byte_i, cfg_i.ident, cfg_i.seq);
    count_d  = (count_q == icmpprc_pkg::CountMax) ? count_q : count_q + 11'd1;

    v4_len_ok    = (count_d >= 11'd28) && (count_d >= hl_w + 11'd8);
    v4_te_len_ok = (count_d >= hl_w + 11'd36);
    v6_len_ok    = (count_d >= 11'd8);
    v6_te_len_ok = (count_d >= 11'd56);

    result_o = '0;
    if (cfg_i.family) begin
      if (v6_len_ok) begin
        if (type_d == icmpprc_pkg::V6EchoReply && omatch_d) begin
          result_o.matched = 1'b1;
          result_o.reached = 1'b1;
        end else if (type_d == icmpprc_pkg::V6TimeExceed && v6_te_len_ok && imatch_d) begin
          result_o.matched = 1'b1;
        end
      end
    end else begin
      if (v4_len_ok) begin
        if (type_d == icmpprc_pkg::V4EchoReply && omatch_d) begin
          result_o.matched = 1'b1;
          result_o.reached = 1'b1;
        end else if (type_d == icmpprc_pkg::V4TimeExceed && code_d == 8'd0 &&
                     v4_te_len_ok && imatch_d) begin
          result_o.matched = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      hl_q     <= icmpprc_pkg::HdrLenMin;
      type_q   <= '0;
      code_q   <= '0;
      omatch_q <= 1'b0;
      imatch_q <= 1'b0;
    end else if (adv_i) begin
      if (last_byte_i) begin
        count_q  <= '0;
        hl_q     <= icmpprc_pkg::HdrLenMin;
        type_q   <= '0;
        code_q   <= '0;
        omatch_q <= 1'b0;
        imatch_q <= 1'b0;
      end else begin
        count_q  <= count_d;
        hl_q     <= hl_d;
        type_q   <= type_d;
        code_q   <= code_d;
        omatch_q <= omatch_d;
        imatch_q <= imatch_d;
      end
    end
  end

endmodule

// ----- hw/rtl/icmp_probe_reply_classifier_unit.sv -----
// top level of the icmp probe reply classifier
//
// packet bytes enter on the input channel (in_valid_i / in_stall_o), one
// request per byte, last_byte_i marking the final byte of a packet. only the
// final byte produces a request on the output channel (out_valid_o /
// out_stall_i) carrying matched_o and reached_o.
// one byte can be taken every cycle while in_stall_o is low. a byte is first
// held in an input register, then the parser updates its packet state and,
// on the final byte, loads the result register, which drives matched_o and
// reached_o.
// while a result waits under out_stall_i, bytes that produce no result keep
// flowing; a final byte waits in the input register, which then raises
// in_stall_o until the result register frees up.
// the config port writes address family, ident and sequence with
// cfg_we_i / cfg_index_i / cfg_data_i; write only while no packet is in flight.
// reset clears all packet state, the config registers and both valid flags;
// the block is ready for bytes as soon as reset is released.
module icmp_probe_reply_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        matched_o,
  output logic        reached_o,
  input  logic        cfg_we_i,
  input  logic [icmpprc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icmpprc_pkg::CfgDataW-1:0] cfg_data_i
);

  icmpprc_pkg::cfg_t    cfg_q;
  icmpprc_pkg::result_t result, result_q;
  logic                 s1_valid_q, s1_last_q;
  logic [7:0]           s1_byte_q;
  logic                 out_valid_q, out_free, s1_adv, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (icmpprc_pkg::cfg_idx_e'(cfg_index_i))
        icmpprc_pkg::CfgFamily: cfg_q.family <= cfg_data_i[0];
        icmpprc_pkg::CfgIdent:  cfg_q.ident  <= cfg_data_i;
        icmpprc_pkg::CfgSeq:    cfg_q.seq    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  icmpprc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = result_q.matched;
  assign reached_o   = result_q.reached;

endmodule
